[rtl/led_status_pattern_sequencer_macros.svh]
// ----------------------------------------------------------------------------
// led status pattern sequencer assertion macros
// shared concurrent assertion wrappers on aclk / aresetn
// ----------------------------------------------------------------------------
`ifndef LED_STATUS_PATTERN_SEQUENCER_MACROS_SVH
`define LED_STATUS_PATTERN_SEQUENCER_MACROS_SVH

// checked only while out of reset
`define LSPS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked at every edge, reset included
`define LSPS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

[rtl/lsps_pkg.sv]
// ----------------------------------------------------------------------------
// lsps_pkg
// shared types, codes and timing constants of the status led sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsps_pkg;

    localparam int DUTY_W = 13;
    localparam int MS_W   = 16;

    localparam logic [1:0] FUNC_TICK         = 2'd0;
    localparam logic [1:0] FUNC_REQUEST      = 2'd1;
    localparam logic [1:0] FUNC_FATAL        = 2'd2;
    localparam logic [1:0] FUNC_CLEAR_SEARCH = 2'd3;

    localparam logic [2:0] PAT_OFF    = 3'd0;
    localparam logic [2:0] PAT_BOOT   = 3'd1;
    localparam logic [2:0] PAT_IDLE   = 3'd2;
    localparam logic [2:0] PAT_SEARCH = 3'd3;
    localparam logic [2:0] PAT_CONN   = 3'd4;
    localparam logic [2:0] PAT_MAINT  = 3'd5;
    localparam logic [2:0] PAT_CODE   = 3'd6;

    localparam logic [1:0] PH_PENDING = 2'd0;
    localparam logic [1:0] PH_LIT     = 2'd1;
    localparam logic [1:0] PH_DARK    = 2'd2;
    localparam logic [1:0] PH_GAP     = 2'd3;

    localparam logic [2:0] CFG_ON_DUTY        = 3'd0;
    localparam logic [2:0] CFG_OFF_DUTY       = 3'd1;
    localparam logic [2:0] CFG_FADE_HIGH_DUTY = 3'd2;
    localparam logic [2:0] CFG_FADE_LOW_DUTY  = 3'd3;
    localparam logic [2:0] CFG_FADE_RAMP_MS   = 3'd4;
    localparam logic [2:0] CFG_FADE_HOLD_MS   = 3'd5;

    localparam logic [3:0] MAX_BLINKS = 4'd15;

    localparam logic [MS_W-1:0] BOOT_MS       = 16'd50;
    localparam logic [MS_W-1:0] IDLE_LIT_MS   = 16'd120;
    localparam logic [MS_W-1:0] IDLE_DARK_MS  = 16'd2880;
    localparam logic [MS_W-1:0] CONN_MS       = 16'd100;
    localparam logic [MS_W-1:0] MAINT_LIT_MS  = 16'd1500;
    localparam logic [MS_W-1:0] MAINT_DARK_MS = 16'd200;
    localparam logic [MS_W-1:0] BLINK_MS      = 16'd150;
    localparam logic [MS_W-1:0] GAP_MS        = 16'd2000;

    typedef struct packed {
        logic [DUTY_W-1:0] on_duty;
        logic [DUTY_W-1:0] off_duty;
        logic [DUTY_W-1:0] fade_high_duty;
        logic [DUTY_W-1:0] fade_low_duty;
        logic [MS_W-1:0]   fade_ramp_ms;
        logic [MS_W-1:0]   fade_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] pattern;
        logic [3:0] blink_count;
    } item_t;

    typedef struct packed {
        logic              update;
        logic [DUTY_W-1:0] duty;
        logic [MS_W-1:0]   ramp_ms;
        logic              accepted;
        logic              fatal;
    } result_t;

    typedef struct packed {
        logic [2:0]      pattern;
        logic [3:0]      blinks;
        logic [1:0]      phase;
        logic [3:0]      blinks_left;
        logic [MS_W-1:0] wait_ms;
        logic            fatal;
    } seq_state_t;

    typedef struct packed {
        logic              update;
        logic [DUTY_W-1:0] duty;
        logic [MS_W-1:0]   ramp_ms;
    } cmd_t;

    typedef struct packed {
        seq_state_t st;
        cmd_t       cmd;
        logic       acc;
    } step_t;

    function automatic logic [MS_W-1:0] lit_ms(input logic [2:0] p);
        logic [MS_W-1:0] r;
        unique case (p)
            PAT_BOOT:  r = BOOT_MS;
            PAT_IDLE:  r = IDLE_LIT_MS;
            PAT_CONN:  r = CONN_MS;
            PAT_MAINT: r = MAINT_LIT_MS;
            default:   r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [MS_W-1:0] dark_ms(input logic [2:0] p);
        logic [MS_W-1:0] r;
        unique case (p)
            PAT_BOOT:  r = BOOT_MS;
            PAT_IDLE:  r = IDLE_DARK_MS;
            PAT_CONN:  r = CONN_MS;
            PAT_MAINT: r = MAINT_DARK_MS;
            default:   r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/lsps_cfg.sv]
// ----------------------------------------------------------------------------
// lsps_cfg
// configuration register file written through the cfg channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsps_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output lsps_pkg::cfg_t      cfg
);

    lsps_pkg::cfg_t cfg_reg;
    lsps_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                lsps_pkg::CFG_ON_DUTY:        cfg_next.on_duty        = cfg_data[12:0];
                lsps_pkg::CFG_OFF_DUTY:       cfg_next.off_duty       = cfg_data[12:0];
                lsps_pkg::CFG_FADE_HIGH_DUTY: cfg_next.fade_high_duty = cfg_data[12:0];
                lsps_pkg::CFG_FADE_LOW_DUTY:  cfg_next.fade_low_duty  = cfg_data[12:0];
                lsps_pkg::CFG_FADE_RAMP_MS:   cfg_next.fade_ramp_ms   = cfg_data;
                lsps_pkg::CFG_FADE_HOLD_MS:   cfg_next.fade_hold_ms   = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.on_duty        <= 13'd8191;
            cfg_reg.off_duty       <= 13'd0;
            cfg_reg.fade_high_duty <= 13'd8191;
            cfg_reg.fade_low_duty  <= 13'd0;
            cfg_reg.fade_ramp_ms   <= 16'd1000;
            cfg_reg.fade_hold_ms   <= 16'd1000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/lsps_in_stage.sv]
// ----------------------------------------------------------------------------
// lsps_in_stage
// input register stage with pass-through backpressure
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsps_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  lsps_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output lsps_pkg::item_t out_item
);

    logic            valid_reg;
    logic            valid_next;
    lsps_pkg::item_t item_reg;
    logic            in_fire;

    assign in_ready   = !valid_reg || out_ready;
    assign in_fire    = in_valid && in_ready;
    assign valid_next = in_fire || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_item   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            item_reg <= in_item;
        end
    end

endmodule

[rtl/lsps_core.sv]
// ----------------------------------------------------------------------------
// lsps_core
// pattern state, per-item step logic and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "led_status_pattern_sequencer_macros.svh"

module lsps_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  lsps_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  lsps_pkg::item_t   in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output lsps_pkg::result_t out_result
);

    lsps_pkg::seq_state_t state_reg;
    lsps_pkg::step_t      step;
    lsps_pkg::result_t    result_reg;
    lsps_pkg::result_t    result_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic                 fire;

    function automatic lsps_pkg::step_t begin_cycle(input lsps_pkg::seq_state_t s,
                                                    input lsps_pkg::cfg_t c);
        lsps_pkg::step_t r;
        r            = '0;
        r.st         = s;
        r.acc        = 1'b0;
        r.cmd.update = 1'b1;
        if (s.pattern == lsps_pkg::PAT_SEARCH) begin
            r.cmd.duty    = c.fade_high_duty;
            r.cmd.ramp_ms = c.fade_ramp_ms;
            r.st.wait_ms  = c.fade_hold_ms;
            r.st.phase    = lsps_pkg::PH_LIT;
        end else if (s.pattern == lsps_pkg::PAT_CODE) begin
            if (s.blinks != 4'd0) begin
                r.cmd.duty       = c.on_duty;
                r.st.blinks_left = s.blinks - 4'd1;
                r.st.wait_ms     = lsps_pkg::BLINK_MS;
                r.st.phase       = lsps_pkg::PH_LIT;
            end else begin
                r.cmd.duty   = c.off_duty;
                r.st.wait_ms = lsps_pkg::GAP_MS;
                r.st.phase   = lsps_pkg::PH_GAP;
            end
        end else if (s.pattern == lsps_pkg::PAT_OFF || s.pattern > lsps_pkg::PAT_CODE) begin
            r.cmd.duty   = c.off_duty;
            r.st.wait_ms = '0;
            r.st.phase   = lsps_pkg::PH_PENDING;
        end else begin
            r.cmd.duty   = c.on_duty;
            r.st.wait_ms = lsps_pkg::lit_ms(s.pattern);
            r.st.phase   = lsps_pkg::PH_LIT;
        end
        return r;
    endfunction

    function automatic lsps_pkg::step_t advance(input lsps_pkg::seq_state_t s,
                                                input lsps_pkg::cfg_t c);
        lsps_pkg::step_t r;
        r            = '0;
        r.st         = s;
        r.cmd.update = 1'b1;
        if (s.pattern == lsps_pkg::PAT_CODE) begin
            if (s.phase == lsps_pkg::PH_LIT) begin
                r.cmd.duty   = c.off_duty;
                r.st.wait_ms = lsps_pkg::BLINK_MS;
                r.st.phase   = lsps_pkg::PH_DARK;
            end else if (s.phase == lsps_pkg::PH_DARK && s.blinks_left != 4'd0) begin
                r.st.blinks_left = s.blinks_left - 4'd1;
                r.cmd.duty       = c.on_duty;
                r.st.wait_ms     = lsps_pkg::BLINK_MS;
                r.st.phase       = lsps_pkg::PH_LIT;
            end else if (s.phase == lsps_pkg::PH_DARK) begin
                r.cmd.duty   = c.off_duty;
                r.st.wait_ms = lsps_pkg::GAP_MS;
                r.st.phase   = lsps_pkg::PH_GAP;
            end else begin
                r = begin_cycle(s, c);
            end
        end else if (s.phase == lsps_pkg::PH_LIT) begin
            if (s.pattern == lsps_pkg::PAT_SEARCH) begin
                r.cmd.duty    = c.fade_low_duty;
                r.cmd.ramp_ms = c.fade_ramp_ms;
                r.st.wait_ms  = c.fade_hold_ms;
            end else begin
                r.cmd.duty   = c.off_duty;
                r.st.wait_ms = lsps_pkg::dark_ms(s.pattern);
            end
            r.st.phase = lsps_pkg::PH_DARK;
        end else begin
            r = begin_cycle(s, c);
        end
        return r;
    endfunction

    function automatic lsps_pkg::step_t request(input lsps_pkg::seq_state_t s,
                                                input lsps_pkg::cfg_t c,
                                                input logic [2:0] pat,
                                                input logic [3:0] count);
        lsps_pkg::step_t      r;
        lsps_pkg::seq_state_t ns;
        logic [3:0]           n;
        logic                 reject;
        r      = '0;
        r.st   = s;
        ns     = s;
        n      = 4'd0;
        reject = 1'b0;
        if (s.fatal || pat > lsps_pkg::PAT_CODE) begin
            reject = 1'b1;
        end
        if (pat == lsps_pkg::PAT_IDLE && s.pattern != lsps_pkg::PAT_OFF &&
            s.pattern != lsps_pkg::PAT_IDLE && s.pattern != lsps_pkg::PAT_BOOT) begin
            reject = 1'b1;
        end
        if (s.pattern == lsps_pkg::PAT_MAINT && pat != lsps_pkg::PAT_MAINT &&
            pat != lsps_pkg::PAT_OFF) begin
            reject = 1'b1;
        end
        if (pat == lsps_pkg::PAT_CODE) begin
            n = (count > lsps_pkg::MAX_BLINKS) ? lsps_pkg::MAX_BLINKS : count;
        end
        if (pat == s.pattern && n == s.blinks) begin
            reject = 1'b1;
        end
        if (!reject) begin
            ns.pattern     = pat;
            ns.blinks      = n;
            ns.blinks_left = 4'd0;
            r              = begin_cycle(ns, c);
            r.acc          = 1'b1;
        end
        return r;
    endfunction

    assign fire         = in_valid && in_ready;
    assign in_ready     = !m_valid_reg || out_ready;
    assign m_valid_next = fire || (m_valid_reg && !out_ready);
    assign out_valid    = m_valid_reg;
    assign out_result   = result_reg;

    always_comb begin
        step    = '0;
        step.st = state_reg;
        unique case (in_item.func)
            lsps_pkg::FUNC_TICK: begin
                if (!state_reg.fatal && state_reg.pattern != lsps_pkg::PAT_OFF) begin
                    if (state_reg.phase == lsps_pkg::PH_PENDING) begin
                        step = begin_cycle(state_reg, cfg);
                    end else if (state_reg.wait_ms > 16'd1) begin
                        step.st.wait_ms = state_reg.wait_ms - 16'd1;
                    end else begin
                        step = advance(state_reg, cfg);
                    end
                end
            end
            lsps_pkg::FUNC_REQUEST: begin
                step = request(state_reg, cfg, in_item.pattern, in_item.blink_count);
            end
            lsps_pkg::FUNC_FATAL: begin
                step.st.fatal    = 1'b1;
                step.cmd.update  = 1'b1;
                step.cmd.duty    = cfg.on_duty;
                step.cmd.ramp_ms = '0;
            end
            lsps_pkg::FUNC_CLEAR_SEARCH: begin
                if (!state_reg.fatal && state_reg.pattern == lsps_pkg::PAT_SEARCH) begin
                    step = request(state_reg, cfg, lsps_pkg::PAT_OFF, 4'd0);
                end
            end
            default: step.st = state_reg;
        endcase
    end

    always_comb begin
        result_next.update   = step.cmd.update;
        result_next.duty     = step.cmd.update ? step.cmd.duty : '0;
        result_next.ramp_ms  = step.cmd.update ? step.cmd.ramp_ms : '0;
        result_next.accepted = step.acc;
        result_next.fatal    = step.st.fatal;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.pattern     <= lsps_pkg::PAT_BOOT;
            state_reg.blinks      <= 4'd0;
            state_reg.phase       <= lsps_pkg::PH_PENDING;
            state_reg.blinks_left <= 4'd0;
            state_reg.wait_ms     <= '0;
            state_reg.fatal       <= 1'b0;
            m_valid_reg           <= 1'b0;
        end else begin
            if (fire) begin
                state_reg <= step.st;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    `LSPS_ASSERT(a_fatal_sticky, state_reg.fatal |=> state_reg.fatal, "fatal latch dropped")
    `LSPS_ASSERT(a_accept_has_cmd, (m_valid_reg && result_reg.accepted) |-> result_reg.update,
        "accepted change without a duty command")
    `LSPS_ASSERT(a_idle_fields_zero,
        (m_valid_reg && !result_reg.update) |-> (result_reg.duty == '0 && result_reg.ramp_ms == '0),
        "idle result carries duty or ramp")
    `LSPS_ASSERT(a_pending_no_wait,
        (state_reg.phase == lsps_pkg::PH_PENDING) |-> (state_reg.wait_ms == '0),
        "pending phase with a running wait")
    `LSPS_ASSERT(a_pattern_legal, state_reg.pattern <= lsps_pkg::PAT_CODE,
        "current pattern outside the defined set")

endmodule

[rtl/led_status_pattern_sequencer.sv]
// ----------------------------------------------------------------------------
// led_status_pattern_sequencer
// status led pattern sequencer driven by millisecond ticks and events
// an input transfer is registered in lsps_in_stage, then in the lsps_core result register
// throughput: one item per cycle unless stalled, as lsps_core updates its state per item
// backpressure on m_tready stalls both register stages in place
// reset: synchronous, active low; pattern boot with first command pending, registers
// back to their defaults, fatal latch clear, no result pending
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_status_pattern_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // pattern[2:0], blink_count[6:3], zero pad
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // update[0], duty[13:1], ramp_ms[29:14],
                                   // accepted[30], fatal[31]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    lsps_pkg::cfg_t    cfg;
    lsps_pkg::item_t   s_item;
    lsps_pkg::item_t   stage_item;
    lsps_pkg::result_t result;
    logic              stage_valid;
    logic              stage_ready;

    assign s_item.func        = s_tuser;
    assign s_item.pattern     = s_tdata[2:0];
    assign s_item.blink_count = s_tdata[6:3];

    assign m_tdata = {result.fatal, result.accepted, result.ramp_ms, result.duty, result.update};

    lsps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsps_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .out_valid (stage_valid),
        .out_ready (stage_ready),
        .out_item  (stage_item)
    );

    lsps_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (stage_valid),
        .in_ready   (stage_ready),
        .in_item    (stage_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

endmodule
